// ===== rtl/cbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// cbsi_pkg
// Shared types and constants of the cartridge bank switcher with its
// scanline interrupt counter.
// ----------------------------------------------------------------------------
package cbsi_pkg;

	// field widths
	localparam int unsigned ADDR_W   = 16;
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned LINE_W   = 9;
	localparam int unsigned PRG_W    = 9;
	localparam int unsigned CHR_W    = 11;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned NUM_CHR  = 8;
	localparam int unsigned SLOT_W   = $clog2(NUM_CHR);

	// remainder unit: dividend is at most 2 * 255
	localparam int unsigned DVD_W     = 9;
	localparam int unsigned MOD_STEPS = DVD_W;
	localparam int unsigned STEP_W    = $clog2(MOD_STEPS);

	// request kinds
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// cpu register addresses
	localparam logic [ADDR_W-1:0] ADDR_PRG0   = 16'h8000;
	localparam logic [ADDR_W-1:0] ADDR_PRG1   = 16'h8001;
	localparam logic [ADDR_W-1:0] ADDR_CHR01  = 16'h8002;
	localparam logic [ADDR_W-1:0] ADDR_CHR23  = 16'h8003;
	localparam logic [ADDR_W-1:0] ADDR_CHR4   = 16'hA000;
	localparam logic [ADDR_W-1:0] ADDR_CHR5   = 16'hA001;
	localparam logic [ADDR_W-1:0] ADDR_CHR6   = 16'hA002;
	localparam logic [ADDR_W-1:0] ADDR_CHR7   = 16'hA003;
	localparam logic [ADDR_W-1:0] ADDR_LATCH  = 16'hC000;
	localparam logic [ADDR_W-1:0] ADDR_IRQEN  = 16'hC001;
	localparam logic [ADDR_W-1:0] ADDR_MIRLCK = 16'hE000;

	// configuration register indexes
	localparam logic CFG_PRG_COUNT = 1'b0;
	localparam logic CFG_CHR_COUNT = 1'b1;

	// misc constants
	localparam int unsigned        MIRROR_BIT     = 6;
	localparam logic [LINE_W-1:0]  LAST_VISIBLE   = 9'd239;
	localparam logic [CNT_W-1:0]   CNT_FIRE       = 8'hFF;
	localparam logic [PRG_W-1:0]   PRG_COUNT_RST  = 9'd16;
	localparam logic [CHR_W-1:0]   CHR_COUNT_RST  = 11'd256;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
		logic [LINE_W-1:0] scanline;
		logic              rendering_on;
	} in_t;

	typedef struct packed {
		logic [PRG_W-1:0] prg_bank_0;
		logic [PRG_W-1:0] prg_bank_1;
		logic [CHR_W-1:0] chr_bank_0;
		logic [CHR_W-1:0] chr_bank_1;
		logic [CHR_W-1:0] chr_bank_2;
		logic [CHR_W-1:0] chr_bank_3;
		logic [CHR_W-1:0] chr_bank_4;
		logic [CHR_W-1:0] chr_bank_5;
		logic [CHR_W-1:0] chr_bank_6;
		logic [CHR_W-1:0] chr_bank_7;
		logic             mirroring;
		logic             irq_request;
	} out_t;

	// remainder unit handshake
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [CHR_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [CHR_W-1:0] remainder;
	} mod_rsp_t;

endpackage

// ===== rtl/cbsi_mod.sv =====
// ----------------------------------------------------------------------------
// cbsi_mod
// Restoring remainder unit: one dividend bit per cycle, one shared
// compare and subtract.
// ----------------------------------------------------------------------------
module cbsi_mod (
	input  logic               clk,
	input  logic               arst_n,
	input  cbsi_pkg::mod_req_t req,
	output cbsi_pkg::mod_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [cbsi_pkg::STEP_W-1:0]   step_q;
	logic [cbsi_pkg::CHR_W-1:0]    rem_q;
	logic [cbsi_pkg::DVD_W-1:0]    dvd_q;
	logic [cbsi_pkg::CHR_W-1:0]    div_q;
	logic [cbsi_pkg::CHR_W:0]      trial;
	logic [cbsi_pkg::CHR_W:0]      diff;
	logic [cbsi_pkg::CHR_W-1:0]    rem_nxt;

	// shift in next bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[cbsi_pkg::DVD_W-1]};
		diff  = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q}) begin
			rem_nxt = diff[cbsi_pkg::CHR_W-1:0];
		end else begin
			rem_nxt = trial[cbsi_pkg::CHR_W-1:0];
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == cbsi_pkg::STEP_W'(cbsi_pkg::MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[cbsi_pkg::DVD_W-2:0], 1'b0};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== rtl/cbsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbsi_ctrl
// Sequencer, mapper state, configuration registers and result register.
// ----------------------------------------------------------------------------
module cbsi_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  cbsi_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cbsi_pkg::out_t               out_data,
	input  logic                         cfg_valid,
	input  logic                         cfg_index,
	input  logic [cbsi_pkg::CHR_W-1:0]   cfg_data,
	output cbsi_pkg::mod_req_t           mod_req,
	input  cbsi_pkg::mod_rsp_t           mod_rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                   state_q;
	cbsi_pkg::in_t                item_q;
	logic [cbsi_pkg::CHR_W-1:0]   rem_q;
	logic [cbsi_pkg::PRG_W-1:0]   prg_cnt_q;
	logic [cbsi_pkg::CHR_W-1:0]   chr_cnt_q;
	logic [cbsi_pkg::PRG_W-1:0]   prg_q [2];
	logic [cbsi_pkg::CHR_W-1:0]   chr_q [cbsi_pkg::NUM_CHR];
	logic                         mirror_q;
	logic                         lock_q;
	logic [cbsi_pkg::CNT_W-1:0]   cnt_q;
	logic                         irq_en_q;
	logic                         out_valid_q;
	cbsi_pkg::out_t               out_q;

	logic                         accept;
	logic                         finish;
	logic                         use_prg;
	logic [cbsi_pkg::PRG_W-1:0]   prg_nxt [2];
	logic [cbsi_pkg::CHR_W-1:0]   chr_nxt [cbsi_pkg::NUM_CHR];
	logic                         mirror_nxt;
	logic                         lock_nxt;
	logic [cbsi_pkg::CNT_W-1:0]   cnt_nxt;
	logic                         irq_en_nxt;
	logic                         pulse;
	logic [cbsi_pkg::CHR_W:0]     rem_inc;
	logic [cbsi_pkg::CHR_W-1:0]   rem_odd;
	logic [cbsi_pkg::SLOT_W-1:0]  slot_even;
	logic [cbsi_pkg::SLOT_W-1:0]  slot_odd;
	logic [cbsi_pkg::SLOT_W-1:0]  slot_single;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign finish    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// remainder request, launched straight off the incoming request
	assign use_prg = (in_data.address == cbsi_pkg::ADDR_PRG0) ||
	                 (in_data.address == cbsi_pkg::ADDR_PRG1);
	always_comb begin
		mod_req.start    = accept;
		mod_req.dividend = use_prg ? {1'b0, in_data.write_data}
		                           : {in_data.write_data, 1'b0};
		mod_req.divisor  = use_prg ? {2'b00, prg_cnt_q} : chr_cnt_q;
	end

	// odd page of a pair: (2d + 1) mod n from 2d mod n
	assign rem_inc     = {1'b0, rem_q} + 1'b1;
	assign rem_odd     = (rem_inc == {1'b0, chr_cnt_q}) ? '0 : rem_inc[cbsi_pkg::CHR_W-1:0];
	assign slot_even   = {1'b0, item_q.address[0], 1'b0};
	assign slot_odd    = {1'b0, item_q.address[0], 1'b1};
	assign slot_single = {1'b1, item_q.address[1:0]};

	// next mapper state
	always_comb begin
		prg_nxt    = prg_q;
		chr_nxt    = chr_q;
		mirror_nxt = mirror_q;
		lock_nxt   = lock_q;
		cnt_nxt    = cnt_q;
		irq_en_nxt = irq_en_q;
		pulse      = 1'b0;
		if (item_q.operation == cbsi_pkg::OP_WRITE) begin
			unique case (item_q.address) inside
				cbsi_pkg::ADDR_PRG0: begin
					if (!lock_q) begin
						mirror_nxt = !item_q.write_data[cbsi_pkg::MIRROR_BIT];
					end
					if (prg_cnt_q != '0) begin
						prg_nxt[0] = rem_q[cbsi_pkg::PRG_W-1:0];
					end
				end
				cbsi_pkg::ADDR_PRG1: begin
					if (prg_cnt_q != '0) begin
						prg_nxt[1] = rem_q[cbsi_pkg::PRG_W-1:0];
					end
				end
				cbsi_pkg::ADDR_CHR01, cbsi_pkg::ADDR_CHR23: begin
					if (chr_cnt_q != '0) begin
						chr_nxt[slot_even] = rem_q;
						chr_nxt[slot_odd]  = rem_odd;
					end
				end
				cbsi_pkg::ADDR_CHR4, cbsi_pkg::ADDR_CHR5,
				cbsi_pkg::ADDR_CHR6, cbsi_pkg::ADDR_CHR7: begin
					if (chr_cnt_q != '0) begin
						chr_nxt[slot_single] = rem_q;
					end
				end
				cbsi_pkg::ADDR_LATCH: begin
					cnt_nxt = item_q.write_data;
				end
				cbsi_pkg::ADDR_IRQEN: begin
					irq_en_nxt = item_q.write_data[0];
				end
				cbsi_pkg::ADDR_MIRLCK: begin
					mirror_nxt = !item_q.write_data[cbsi_pkg::MIRROR_BIT];
					lock_nxt   = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (irq_en_q && item_q.rendering_on &&
		             (item_q.scanline <= cbsi_pkg::LAST_VISIBLE)) begin
			if (cnt_q == cbsi_pkg::CNT_FIRE) begin
				pulse      = 1'b1;
				irq_en_nxt = 1'b0;
			end else begin
				cnt_nxt = cnt_q + 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept)       state_q <= ST_MOD;
				ST_MOD:  if (mod_rsp.done) state_q <= ST_DONE;
				ST_DONE: if (finish)       state_q <= ST_IDLE;
				default:                   state_q <= ST_IDLE;
			endcase
		end
	end

	// request and remainder capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (mod_rsp.done) begin
			rem_q <= mod_rsp.remainder;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_cnt_q <= cbsi_pkg::PRG_COUNT_RST;
			chr_cnt_q <= cbsi_pkg::CHR_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cbsi_pkg::CFG_PRG_COUNT: prg_cnt_q <= cfg_data[cbsi_pkg::PRG_W-1:0];
				cbsi_pkg::CFG_CHR_COUNT: chr_cnt_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// mapper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_q[0] <= cbsi_pkg::PRG_W'(0);
			prg_q[1] <= cbsi_pkg::PRG_W'(1);
			for (int i = 0; i < cbsi_pkg::NUM_CHR; i++) begin
				chr_q[i] <= cbsi_pkg::CHR_W'(i);
			end
			mirror_q <= 1'b0;
			lock_q   <= 1'b0;
			cnt_q    <= '0;
			irq_en_q <= 1'b0;
		end else if (finish) begin
			prg_q    <= prg_nxt;
			chr_q    <= chr_nxt;
			mirror_q <= mirror_nxt;
			lock_q   <= lock_nxt;
			cnt_q    <= cnt_nxt;
			irq_en_q <= irq_en_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.prg_bank_0  <= prg_nxt[0];
			out_q.prg_bank_1  <= prg_nxt[1];
			out_q.chr_bank_0  <= chr_nxt[0];
			out_q.chr_bank_1  <= chr_nxt[1];
			out_q.chr_bank_2  <= chr_nxt[2];
			out_q.chr_bank_3  <= chr_nxt[3];
			out_q.chr_bank_4  <= chr_nxt[4];
			out_q.chr_bank_5  <= chr_nxt[5];
			out_q.chr_bank_6  <= chr_nxt[6];
			out_q.chr_bank_7  <= chr_nxt[7];
			out_q.mirroring   <= mirror_nxt;
			out_q.irq_request <= pulse;
		end
	end

endmodule

// ===== rtl/cartridge_bank_and_scanline_irq.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_and_scanline_irq
// Cartridge bank switcher with a scanline interrupt counter.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request, either a cpu register write or a scanline tick.
//   out_* : one result per request with all switchable program and
//           character banks, the mirroring and a one-result irq pulse.
//   cfg_* : page counts for program (index 0) and character (index 1)
//           pages; cfg_ready is always high, write only while idle.
// Timing:
//   a request passes through the bit-serial remainder unit (one dividend
//   bit per cycle, 9 bits), then a capture and an update step. in_ready
//   is low in between and during the update, so a new request is taken
//   only once the last one has been finished.
// Stall:
//   the result register holds a waiting result; a new request is taken
//   meanwhile and is finished once the waiting result has been taken.
// Reset:
//   arst_n clears the sequencer, loads the bank reset pages and the
//   default page counts (16 program, 256 character).
// ----------------------------------------------------------------------------
module cartridge_bank_and_scanline_irq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cbsi_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cbsi_pkg::out_t              out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [cbsi_pkg::CHR_W-1:0]  cfg_data
);

	cbsi_pkg::mod_req_t mod_req;
	cbsi_pkg::mod_rsp_t mod_rsp;

	assign cfg_ready = 1'b1;

	// sequencer and mapper state
	cbsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mod_req   (mod_req),
		.mod_rsp   (mod_rsp)
	);

	// shared remainder unit
	cbsi_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

endmodule

// ===== rtl/cbsi_checker.sv =====
// ----------------------------------------------------------------------------
// cbsi_checker
// Port level checks of the bank switcher, bound to the top level.
// ----------------------------------------------------------------------------
module cbsi_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input cbsi_pkg::out_t              out_data,
	input logic                        cfg_valid,
	input logic                        cfg_ready
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one request in flight at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a new result only appears while a request is being finished
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without a request in flight");

	// configuration is never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind cartridge_bank_and_scanline_irq cbsi_checker u_cbsi_checker (.*);
